[hdl/assert_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define RSCF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that is checked during reset as well.
`define RSCF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/rscf_pkg.sv]
`default_nettype none

package rscf_pkg;

  localparam int RING_SIZE_DEF    = 48;
  localparam int MAX_CLUSTERS_DEF = 4;

  // Result field widths are fixed by the interface.
  localparam int POS_W     = 6;
  localparam int COUNT_W   = 3;
  localparam int OUT_SLOTS = 4;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam pos_t INVALID_POS = '1;

  // Outcome of one scan of a sensor word.
  typedef struct packed {
    logic                         fail;
    count_t                       count;
    logic [OUT_SLOTS-1:0][POS_W-1:0] starts;
    logic [OUT_SLOTS-1:0][POS_W-1:0] ends;
  } scan_res_t;

endpackage

`default_nettype wire

[hdl/ring_sensor_cluster_finder.sv]
// Channel   Ports                                     Transfer when
// input     start, busy, in_sensor_bits               start high and busy low
// result    out_valid, out_cluster_count, out_start_*  out_valid high (one cycle)
//           out_end_*, out_filled_in
// config    cfg_wr_en, cfg_wr_data                    cfg_wr_en high
//
// Every sensor word gives one result: the word is held in the input
// register, then passes through the scan logic into the result
// register. busy stays low, so a word can be transferred every cycle.
// The result path cannot be stalled; each result is shown for one cycle.
// Reset (synchronous, active low) clears the valid flags and sets
// fill-in enable.
`default_nettype none
`include "assert_macros.svh"

module ring_sensor_cluster_finder #(
  parameter int RING_SIZE    = rscf_pkg::RING_SIZE_DEF,
  parameter int MAX_CLUSTERS = rscf_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [RING_SIZE-1:0]         in_sensor_bits,
  // Configuration
  input  wire logic                         cfg_wr_en,
  input  wire logic                         cfg_wr_data,
  // Result channel
  output logic                              out_valid,
  output logic [rscf_pkg::COUNT_W-1:0]      out_cluster_count,
  output logic [rscf_pkg::POS_W-1:0]        out_start_a,
  output logic [rscf_pkg::POS_W-1:0]        out_start_b,
  output logic [rscf_pkg::POS_W-1:0]        out_start_c,
  output logic [rscf_pkg::POS_W-1:0]        out_start_d,
  output logic [rscf_pkg::POS_W-1:0]        out_end_a,
  output logic [rscf_pkg::POS_W-1:0]        out_end_b,
  output logic [rscf_pkg::POS_W-1:0]        out_end_c,
  output logic [rscf_pkg::POS_W-1:0]        out_end_d,
  output logic                              out_filled_in
);
  import rscf_pkg::*;

  // Configuration register.
  logic fill_en_r;

  // Input stage.
  logic                 in_valid_r;
  logic [RING_SIZE-1:0] word_r;

  // Result stage.
  logic                            out_valid_r;
  count_t                          count_r;
  logic [OUT_SLOTS-1:0][POS_W-1:0] starts_r;
  logic [OUT_SLOTS-1:0][POS_W-1:0] ends_r;
  logic                            filled_r;

  logic                 accept;
  logic [RING_SIZE-1:0] filled_word;
  scan_res_t            plain_res;
  scan_res_t            fill_res;
  scan_res_t            sel_res;
  logic                 use_fill;

  // The block never holds off a word.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      fill_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_sensor_bits;
    end
  end

  // Fill-in: an off sensor whose two ring neighbors are both on is turned
  // on. The upper neighbor of the last sensor is sensor 0 and the lower
  // neighbor of sensor 0 is the last sensor.
  assign filled_word = word_r |
                       ({word_r[0], word_r[RING_SIZE-1:1]} &
                        {word_r[RING_SIZE-2:0], word_r[RING_SIZE-1]});

  // Both scans run side by side; the filled one is only used when the plain
  // scan finds too many runs and fill-in is enabled.
  rscf_scan #(
    .RING_SIZE    (RING_SIZE),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_scan_plain (
    .word (word_r),
    .res  (plain_res)
  );

  rscf_scan #(
    .RING_SIZE    (RING_SIZE),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_scan_fill (
    .word (filled_word),
    .res  (fill_res)
  );

  // A failed scan already reports zero clusters and every position invalid,
  // so a failed retry passes straight through.
  assign use_fill = plain_res.fail & fill_en_r;
  assign sel_res  = use_fill ? fill_res : plain_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      count_r  <= sel_res.count;
      starts_r <= sel_res.starts;
      ends_r   <= sel_res.ends;
      filled_r <= use_fill;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cluster_count = count_r;
  assign out_start_a       = starts_r[0];
  assign out_start_b       = starts_r[1];
  assign out_start_c       = starts_r[2];
  assign out_start_d       = starts_r[3];
  assign out_end_a         = ends_r[0];
  assign out_end_b         = ends_r[1];
  assign out_end_c         = ends_r[2];
  assign out_end_d         = ends_r[3];
  assign out_filled_in     = filled_r;

  // Every transferred word produces its result, through the input and result registers.
  `RSCF_ASSERT(a_result_latency, clk, rst_n, accept |=> ##1 out_valid, "result missing after transfer")

  // No result appears without an earlier transferred word behind it.
  `RSCF_ASSERT(a_no_spurious, clk, rst_n, out_valid |-> $past(accept, 2), "result without transfer")

  // A closed cluster always has a valid end; without one the count is zero.
  `RSCF_ASSERT(a_count_end, clk, rst_n, out_valid |-> ((out_cluster_count == '0) == (out_end_a == INVALID_POS)), "count and first end disagree")

  // The count never reaches the cluster limit.
  `RSCF_ASSERT(a_count_range, clk, rst_n, out_valid |-> (int'(out_cluster_count) < MAX_CLUSTERS), "cluster count out of range")

  // Reset leaves no result pending.
  `RSCF_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid, "result strobe after reset")

endmodule

`default_nettype wire

[hdl/rscf_scan.sv]
`default_nettype none

module rscf_scan #(
  parameter int RING_SIZE    = rscf_pkg::RING_SIZE_DEF,
  parameter int MAX_CLUSTERS = rscf_pkg::MAX_CLUSTERS_DEF
) (
  input  wire logic [RING_SIZE-1:0] word,
  output rscf_pkg::scan_res_t       res
);
  import rscf_pkg::*;

  localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
  localparam int NSLOT = (MAX_CLUSTERS < OUT_SLOTS) ? MAX_CLUSTERS : OUT_SLOTS;

  logic [RING_SIZE-1:0]    rise_m;
  logic [RING_SIZE-1:0]    end_m;
  logic [RING_SIZE-1:0]    rm;
  logic [RING_SIZE-1:0]    em;
  logic [MAX_CLUSTERS-1:0] rise_found;
  logic [MAX_CLUSTERS-1:0] end_found;
  pos_t                    rise_pos [MAX_CLUSTERS];
  pos_t                    end_pos  [MAX_CLUSTERS];
  logic [CNT_W-1:0]        nfall;
  logic [CNT_W-1:0]        count;
  logic                    closes_open;
  logic                    merges;
  logic                    fail;
  pos_t                    merged_start;

  function automatic pos_t pos_of(input logic [RING_SIZE-1:0] onehot);
    pos_t p;
    p = '0;
    for (int i = 0; i < RING_SIZE; i++) begin
      if (onehot[i]) p = p | POS_W'(i);
    end
    return p;
  endfunction

  // A run starts where a bit is set and its lower neighbor is clear, and
  // ends where a bit is set and its upper neighbor is clear. The top bit
  // never closes a run inside the scan.
  assign rise_m = word & ~{word[RING_SIZE-2:0], 1'b0};
  assign end_m  = word & ~{1'b1, word[RING_SIZE-1:1]};

  // Peel off the lowest edge once per cluster slot.
  always_comb begin
    rm = rise_m;
    em = end_m;
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      rise_found[k] = |rm;
      rise_pos[k]   = pos_of(rm & ~(rm - RING_SIZE'(1)));
      rm            = rm & (rm - RING_SIZE'(1));
      end_found[k]  = |em;
      end_pos[k]    = pos_of(em & ~(em - RING_SIZE'(1)));
      em            = em & (em - RING_SIZE'(1));
    end
  end

  always_comb begin
    nfall = '0;
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      nfall = nfall + CNT_W'(end_found[k]);
    end
  end

  assign closes_open = word[RING_SIZE-1] & ~word[0];
  assign merges      = word[RING_SIZE-1] & word[0];
  assign fail        = end_found[MAX_CLUSTERS-1] |
                       (closes_open & ((int'(nfall) + 1) >= MAX_CLUSTERS));
  assign count       = nfall + CNT_W'(closes_open);

  always_comb begin
    merged_start = rise_pos[0];
    for (int j = 0; j < MAX_CLUSTERS; j++) begin
      if (CNT_W'(j) == nfall) merged_start = rise_pos[j];
    end
  end

  always_comb begin
    res.fail   = fail;
    res.count  = fail ? '0 : COUNT_W'(count);
    res.starts = {OUT_SLOTS{INVALID_POS}};
    res.ends   = {OUT_SLOTS{INVALID_POS}};
    if (!fail) begin
      for (int k = 0; k < NSLOT; k++) begin
        if (rise_found[k]) res.starts[k] = rise_pos[k];
        if (end_found[k]) begin
          res.ends[k] = end_pos[k];
        end else if (closes_open && (CNT_W'(k) == nfall)) begin
          res.ends[k] = POS_W'(RING_SIZE - 1);
        end
      end
      if (merges) res.starts[0] = merged_start;
    end
  end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rscf_pkg::*;

  localparam int RING_BITS     = RING_SIZE_DEF;
  localparam int CLUSTER_SLOTS = MAX_CLUSTERS_DEF;
  // Generous bound on the whole run: roughly 430 transfers with idle gaps between
  // them, plus the register writes and the drain waits between phases.
  localparam int CYCLE_LIMIT   = 50000;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_WORDS   = 80;

  // One expected result, laid out the same way as the result ports.
  typedef struct packed {
    count_t                      count;
    pos_t [OUT_SLOTS-1:0]        starts;
    pos_t [OUT_SLOTS-1:0]        ends;
    logic                        filled;
  } cluster_result_t;

  // Outcome of a single pass over the ring.
  typedef struct packed {
    logic                        too_many;
    int                          count;
    pos_t [OUT_SLOTS-1:0]        starts;
    pos_t [OUT_SLOTS-1:0]        ends;
  } ring_scan_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [RING_BITS-1:0]   in_sensor_bits = '0;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;
  logic                   out_valid;
  count_t                 out_cluster_count;
  pos_t                   out_start_a, out_start_b, out_start_c, out_start_d;
  pos_t                   out_end_a, out_end_b, out_end_c, out_end_d;
  logic                   out_filled_in;

  // Sensor words waiting to be driven, and the results the predictor expects
  // for words already transferred, oldest first.
  logic [RING_BITS-1:0]   sensor_word_q[$];
  cluster_result_t        pending_clusters_q[$];

  // Our own copy of the fill-in enable register.
  logic                   fill_enable_model = 1'b1;
  // When low, the sender presents words back to back.
  bit                     idle_sender = 1'b1;
  int                     hold_cycles = 0;
  int                     mismatches = 0;
  int                     cycle_count = 0;
  string                  slot_tag[OUT_SLOTS] = '{"a", "b", "c", "d"};
  logic [RING_BITS-1:0]   directed_words[12];

  ring_sensor_cluster_finder i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sensor_bits    (in_sensor_bits),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_cluster_count (out_cluster_count),
    .out_start_a       (out_start_a),
    .out_start_b       (out_start_b),
    .out_start_c       (out_start_c),
    .out_start_d       (out_start_d),
    .out_end_a         (out_end_a),
    .out_end_b         (out_end_b),
    .out_end_c         (out_end_c),
    .out_end_d         (out_end_d),
    .out_filled_in     (out_filled_in)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor.
  // ---------------------------------------------------------------------------

  // Switch on every off sensor whose two ring neighbors are both on. The
  // neighbors are taken from the original word, so a gap is only closed when
  // it is a single sensor wide.
  function automatic logic [RING_BITS-1:0] fill_single_gaps(input logic [RING_BITS-1:0] w);
    logic [RING_BITS-1:0] r;
    int i, lo, hi;
    r = w;
    for (i = 0; i < RING_BITS; i++) begin
      lo = (i == 0) ? RING_BITS - 1 : i - 1;
      hi = (i == RING_BITS - 1) ? 0 : i + 1;
      if (!w[i] && w[lo] && w[hi])
        r[i] = 1'b1;
    end
    return r;
  endfunction

  // Walk the ring from sensor 0 upward and record each run of on-sensors.
  // Closing the slot limit's worth of runs counts as too many, even if the
  // scan would have ended there.
  function automatic ring_scan_t scan_runs(input logic [RING_BITS-1:0] w);
    ring_scan_t s;
    int i, k, idx, opened;
    logic prev;
    s.too_many = 1'b0;
    s.count    = 0;
    for (k = 0; k < OUT_SLOTS; k++) begin
      s.starts[k] = INVALID_POS;
      s.ends[k]   = INVALID_POS;
    end
    idx  = 0;
    prev = 1'b0;
    for (i = 0; i < RING_BITS; i++) begin
      if (w[i] && !prev)
        s.starts[idx] = pos_t'(i);
      if (!w[i] && prev) begin
        s.ends[idx] = pos_t'(i - 1);
        idx++;
        if (idx >= CLUSTER_SLOTS) begin
          s.too_many = 1'b1;
          return s;
        end
      end
      prev = w[i];
    end
    // A run that was opened but never closed is still on at the last sensor.
    opened = 0;
    for (k = 0; k < CLUSTER_SLOTS; k++)
      if (s.starts[k] != INVALID_POS)
        opened++;
    if (opened != idx) begin
      if (s.starts[0] == pos_t'(0)) begin
        // The open run wraps into the first one. Its own slot keeps the start
        // and an invalid end, and it is not counted.
        s.starts[0] = s.starts[idx];
      end else begin
        s.ends[idx] = pos_t'(RING_BITS - 1);
        idx++;
        if (idx >= CLUSTER_SLOTS) begin
          s.too_many = 1'b1;
          return s;
        end
      end
    end
    s.count = idx;
    return s;
  endfunction

  function automatic cluster_result_t predict_clusters(input logic [RING_BITS-1:0] w,
                                                       input logic fill_en);
    cluster_result_t res;
    ring_scan_t      s;
    int              k;
    res.filled = 1'b0;
    s = scan_runs(w);
    if (s.too_many && fill_en) begin
      res.filled = 1'b1;
      s = scan_runs(fill_single_gaps(w));
    end
    if (s.too_many) begin
      s.count = 0;
      for (k = 0; k < OUT_SLOTS; k++) begin
        s.starts[k] = INVALID_POS;
        s.ends[k]   = INVALID_POS;
      end
    end
    res.count  = count_t'(s.count);
    res.starts = s.starts;
    res.ends   = s.ends;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation.
  // ---------------------------------------------------------------------------

  function automatic logic [RING_BITS-1:0] random_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[RING_BITS-1:0];
  endfunction

  // Half of the words are built from a handful of runs at random places on the ring,
  // so that the merge, the closing at the last sensor and the fill-in retry
  // are all reached often. The rest is raw noise, sparse or dense words, and
  // nearly full rings with holes punched into them.
  function automatic logic [RING_BITS-1:0] make_ring_word();
    logic [RING_BITS-1:0] w;
    int kind, runs, pos, len, j, r;
    kind = $urandom_range(0, 9);
    w    = '0;
    case (kind)
      0: w = random_word();
      6: w = random_word() & random_word() & random_word();
      7: w = random_word() | random_word();
      8, 9: begin
        w    = '1;
        runs = $urandom_range(1, (kind == 8) ? 3 : 8);
        for (r = 0; r < runs; r++)
          w[$urandom_range(0, RING_BITS - 1)] = 1'b0;
      end
      default: begin
        pos  = $urandom_range(0, RING_BITS - 1);
        runs = $urandom_range(1, 5);
        for (r = 0; r < runs; r++) begin
          len = $urandom_range(1, 8);
          for (j = 0; j < len; j++)
            w[(pos + j) % RING_BITS] = 1'b1;
          // Gaps of one sensor are common so that fill-in has work to do.
          pos = (pos + len + $urandom_range(1, 4)) % RING_BITS;
        end
      end
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the queued words one at a time. A word is transferred at
  // the edge where start is high and busy is low. The prediction is made at
  // that edge, with the register value in force then.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start          <= 1'b0;
      in_sensor_bits <= '0;
      hold_cycles    <= 0;
    end else begin
      if (start && !busy)
        pending_clusters_q.push_back(predict_clusters(in_sensor_bits, fill_enable_model));
      if (!start || !busy) begin
        if (hold_cycles > 0) begin
          hold_cycles <= hold_cycles - 1;
          start       <= 1'b0;
        end else if (sensor_word_q.size() > 0) begin
          in_sensor_bits <= sensor_word_q.pop_front();
          start          <= 1'b1;
          // Cycles to sit idle after this word's transfer.
          hold_cycles    <= idle_sender ? int'($urandom_range(0, 3)) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // The register copy follows every write the block sees.
  always @(posedge clk) begin
    if (!rst_n)
      fill_enable_model <= 1'b1;
    else if (cfg_wr_en)
      fill_enable_model <= cfg_wr_data;
  end

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: every result is shown for exactly one cycle, so each cycle with
  // out_valid high is a transfer and is checked against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    cluster_result_t want, got;
    int k;
    if (rst_n && out_valid === 1'b1) begin
      got.count     = out_cluster_count;
      got.starts[0] = out_start_a;
      got.starts[1] = out_start_b;
      got.starts[2] = out_start_c;
      got.starts[3] = out_start_d;
      got.ends[0]   = out_end_a;
      got.ends[1]   = out_end_b;
      got.ends[2]   = out_end_c;
      got.ends[3]   = out_end_d;
      got.filled    = out_filled_in;
      if (pending_clusters_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual count %0d", $time,
                 got.count);
        mismatches++;
      end else begin
        want = pending_clusters_q.pop_front();
        check_field("cluster_count", want.count, got.count);
        for (k = 0; k < OUT_SLOTS; k++) begin
          check_field({"start_", slot_tag[k]}, want.starts[k], got.starts[k]);
          check_field({"end_", slot_tag[k]}, want.ends[k], got.ends[k]);
        end
        check_field("filled_in", want.filled, got.filled);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Block until every queued word has been transferred and every expected
  // result has come back. Queues are looked at on the falling edge so that
  // the clocked blocks have settled.
  task automatic wait_until_drained();
    @(negedge clk);
    while (sensor_word_q.size() != 0 || start || pending_clusters_q.size() != 0)
      @(negedge clk);
  endtask

  // The block is idle whenever this is called, so the write cannot fall on a
  // word that is in flight.
  task automatic write_fill_enable(input logic value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Directed words, each aimed at one corner of the scan.
    directed_words[0]  = 48'h0000_0000_0000; // nothing on
    directed_words[1]  = 48'hFFFF_FFFF_FFFF; // whole ring on
    directed_words[2]  = 48'h8000_0000_0000; // only the last sensor
    directed_words[3]  = 48'hF000_0000_0007; // run wraps and merges into sensor 0
    directed_words[4]  = 48'hFF00_0000_0000; // run closed at the last sensor
    directed_words[5]  = 48'h0000_0070_0F03; // three closed runs
    directed_words[6]  = 48'h0000_0000_0DB6; // four runs, single gaps fill in
    directed_words[7]  = 48'h0000_0000_3333; // four runs, gaps too wide to fill
    directed_words[8]  = 48'hAAAA_AAAA_AAAA; // alternating, fills to all on
    directed_words[9]  = 48'h5555_5555_5555; // alternating, last sensor filled
    directed_words[10] = 48'hC000_0070_0F03; // three runs plus a wrapping merge
    directed_words[11] = 48'hC000_0070_0F06; // open last run overflows, fill saves it

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The directed words go through once with the reset value of the
    // register and once with fill-in turned off.
    idle_sender = 1'b1;
    foreach (directed_words[i])
      sensor_word_q.push_back(directed_words[i]);
    wait_until_drained();
    write_fill_enable(1'b0);
    foreach (directed_words[i])
      sensor_word_q.push_back(directed_words[i]);

    // Random phases. Each one starts from a drained block, so the sender has
    // paused until every expected result came back. Odd phases run without
    // any idle cycles on the sender side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_until_drained();
      write_fill_enable((p == 0 || p == 3) ? 1'b0 : 1'b1);
      idle_sender = (p % 2 == 0);
      for (int n = 0; n < PHASE_WORDS; n++)
        sensor_word_q.push_back(make_ring_word());
    end

    wait_until_drained();
    // A few more cycles to catch any stray result beyond the last one.
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/rscf_pkg.sv
hdl/rscf_scan.sv
hdl/ring_sensor_cluster_finder.sv
tb/tb.sv
